>>> rtl/core/tree_ancestor_query_engine_defines.svh
// ---------------------------------------------------------------------------
// Tree ancestor query engine: assertion macros
// Shared property templates for the checker of the ancestor engine.
// ---------------------------------------------------------------------------
`ifndef TREE_ANCESTOR_QUERY_ENGINE_DEFINES_SVH
`define TREE_ANCESTOR_QUERY_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TQE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TQE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tqe_pkg.sv
// ---------------------------------------------------------------------------
// Tree ancestor query engine package
// Sizes, word types, port bundles and address helpers shared by the engine.
// ---------------------------------------------------------------------------
package tqe_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int LEVELS     = 11;

   localparam int KIND_W     = 2;
   localparam int NODE_W     = 10;
   localparam int DEPTH_W    = 10;
   localparam int DIST_W     = 11;

   localparam int SLOT_W     = $clog2(MAX_NODES);
   localparam int LVL_IDX_W  = $clog2(LEVELS);
   localparam int LVL_W      = $clog2(LEVELS + 1);
   localparam int ANC_ADDR_W = SLOT_W + LVL_IDX_W;
   // one row of 2**LVL_IDX_W entries per node, upper entries of a row unused
   localparam int ANC_DEPTH  = MAX_NODES << LVL_IDX_W;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [DIST_W-1:0]  dist_type;

   localparam kind_type  KIND_LOAD = kind_type'(0);
   localparam kind_type  KIND_PAIR = kind_type'(1);
   localparam kind_type  KIND_KTH  = kind_type'(2);

   localparam depth_type DEPTH_MAX = '1;

   typedef struct packed {
      kind_type kind;
      node_type node_a;
      node_type node_b;
      node_type parent_node;
      node_type steps;
   } req_type;

   typedef struct packed {
      node_type result_node;
      dist_type distance;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ANC_ADDR_W-1:0] wr_addr;
      node_type              wr_data;
      logic [ANC_ADDR_W-1:0] rd_addr0;
      logic [ANC_ADDR_W-1:0] rd_addr1;
   } anc_port_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      depth_type         wr_data;
      logic [SLOT_W-1:0] rd_addr0;
      logic [SLOT_W-1:0] rd_addr1;
   } dep_port_type;

   // node number modulo the node count; plain truncation for a power of two
   function automatic logic [SLOT_W-1:0] slot_of(input node_type n);
      logic [31:0] r;
      r = 32'(n);
      for (int j = NODE_W - 1; j >= 0; j--) begin
         if (r >= (32'(MAX_NODES) << j)) begin
            r = r - (32'(MAX_NODES) << j);
         end
      end
      return SLOT_W'(r);
   endfunction

   function automatic logic [ANC_ADDR_W-1:0] anc_addr(input node_type n,
                                                       input logic [LVL_IDX_W-1:0] lvl);
      return {slot_of(n), lvl};
   endfunction

endpackage

>>> rtl/core/tqe_ram.sv
// ---------------------------------------------------------------------------
// Tree ancestor query engine RAM
// One write port, two registered read ports; a read of the entry written in
// the same cycle returns the new word.
// ---------------------------------------------------------------------------
module tqe_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q0_ff;
   logic [WIDTH-1:0] q1_ff;
   logic [WIDTH-1:0] wdata_ff;
   logic             byp0_ff;
   logic             byp1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q0_ff    <= mem_ff[rd_addr0];
      q1_ff    <= mem_ff[rd_addr1];
      byp0_ff  <= wr_en && (wr_addr == rd_addr0);
      byp1_ff  <= wr_en && (wr_addr == rd_addr1);
      wdata_ff <= wr_data;
   end

   assign rd_data0 = byp0_ff ? wdata_ff : q0_ff;
   assign rd_data1 = byp1_ff ? wdata_ff : q1_ff;

endmodule

>>> rtl/core/tqe_ctrl.sv
// ---------------------------------------------------------------------------
// Tree ancestor query engine sequencer
// Walks the ancestor and depth memories one level per step for loads,
// pair queries and kth-ancestor queries, and registers the result word.
// ---------------------------------------------------------------------------
module tqe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tqe_pkg::req_type      req_word,
   output logic                  rsp_valid,
   output tqe_pkg::rsp_type      rsp_word,
   output tqe_pkg::anc_port_type anc_port,
   input  tqe_pkg::node_type     anc_q0,
   input  tqe_pkg::node_type     anc_q1,
   output tqe_pkg::dep_port_type dep_port,
   input  tqe_pkg::depth_type    dep_q0,
   input  tqe_pkg::depth_type    dep_q1
);

   import tqe_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_NOP     = 4'd1;
   localparam logic [3:0] S_L_DEP   = 4'd2;
   localparam logic [3:0] S_L_INIT  = 4'd3;
   localparam logic [3:0] S_L_FILL  = 4'd4;
   localparam logic [3:0] S_K_DEP   = 4'd5;
   localparam logic [3:0] S_K_CLAMP = 4'd6;
   localparam logic [3:0] S_K_WALK  = 4'd7;
   localparam logic [3:0] S_Q_DEP   = 4'd8;
   localparam logic [3:0] S_Q_SWAP  = 4'd9;
   localparam logic [3:0] S_Q_UP    = 4'd10;
   localparam logic [3:0] S_Q_CMP   = 4'd11;
   localparam logic [3:0] S_Q_P2    = 4'd12;
   localparam logic [3:0] S_Q_FIN   = 4'd13;
   localparam logic [3:0] S_Q_DIST  = 4'd14;

   localparam logic [LVL_IDX_W-1:0] TOP_IDX   = LVL_IDX_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0]     LVL_TOP   = LVL_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0]     LVL_END   = LVL_W'(LEVELS);

   logic [3:0]        state_ff, state_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   req_type           req_ff, req_in;
   node_type          a_ff, a_in;
   node_type          b_ff, b_in;
   node_type          up_ff, up_in;
   depth_type         db_ff, db_in;
   dist_type          dsum_ff, dsum_in;
   logic [LEVELS-1:0] k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LVL_IDX_W-1:0] lvl_idx;
   logic [LVL_IDX_W-1:0] lvl_dn_idx;

   assign lvl_idx    = LVL_IDX_W'(lvl_ff);
   assign lvl_dn_idx = LVL_IDX_W'(lvl_ff - 1'b1);

   always_comb begin
      node_type  a_next;
      node_type  b_next;
      node_type  kc;
      depth_type d_new;
      dist_type  two_d;

      state_in     = state_ff;
      lvl_in       = lvl_ff;
      req_in       = req_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      up_in        = up_ff;
      db_in        = db_ff;
      dsum_in      = dsum_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      anc_port     = '0;
      dep_port     = '0;
      a_next       = a_ff;
      b_next       = b_ff;
      kc           = req_ff.steps;
      d_new        = '0;
      two_d        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_word;
               unique case (req_word.kind)
                  KIND_LOAD: state_in = S_L_DEP;
                  KIND_PAIR: state_in = S_Q_DEP;
                  KIND_KTH:  state_in = S_K_DEP;
                  default:   state_in = S_NOP;
               endcase
            end
         end

         S_NOP: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         // ---- load: depth from parent, then fill the row level by level ----
         S_L_DEP: begin
            dep_port.rd_addr0 = slot_of(req_ff.parent_node);
            state_in          = S_L_INIT;
         end

         S_L_INIT: begin
            if (req_ff.parent_node == req_ff.node_a) begin
               d_new = '0;
            end else if (dep_q0 == DEPTH_MAX) begin
               d_new = DEPTH_MAX;
            end else begin
               d_new = dep_q0 + 1'b1;
            end
            dep_port.wr_en    = 1'b1;
            dep_port.wr_addr  = slot_of(req_ff.node_a);
            dep_port.wr_data  = d_new;
            anc_port.wr_en    = 1'b1;
            anc_port.wr_addr  = anc_addr(req_ff.node_a, '0);
            anc_port.wr_data  = req_ff.parent_node;
            anc_port.rd_addr0 = anc_addr(req_ff.parent_node, '0);
            rsp_in.result_node = req_ff.node_a;
            rsp_in.distance    = DIST_W'(d_new);
            lvl_in             = LVL_W'(1);
            state_in           = S_L_FILL;
         end

         S_L_FILL: begin
            // a row that points at itself is served by the RAM bypass
            anc_port.wr_en    = 1'b1;
            anc_port.wr_addr  = anc_addr(req_ff.node_a, lvl_idx);
            anc_port.wr_data  = anc_q0;
            anc_port.rd_addr0 = anc_addr(anc_q0, lvl_idx);
            if (lvl_ff == LVL_TOP) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end

         // ---- kth ancestor: clamp to depth, then jump on each set bit ----
         S_K_DEP: begin
            dep_port.rd_addr0 = slot_of(req_ff.node_a);
            state_in          = S_K_CLAMP;
         end

         S_K_CLAMP: begin
            kc = (req_ff.steps > NODE_W'(dep_q0)) ? NODE_W'(dep_q0) : req_ff.steps;
            k_in              = LEVELS'(kc);
            a_in              = req_ff.node_a;
            anc_port.rd_addr0 = anc_addr(req_ff.node_a, '0);
            lvl_in            = LVL_W'(1);
            state_in          = S_K_WALK;
         end

         S_K_WALK: begin
            a_next = k_ff[lvl_dn_idx] ? anc_q0 : a_ff;
            if (lvl_ff == LVL_END) begin
               rsp_in.result_node = a_next;
               rsp_in.distance    = '0;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else begin
               anc_port.rd_addr0 = anc_addr(a_next, lvl_idx);
               a_in              = a_next;
               lvl_in            = lvl_ff + 1'b1;
            end
         end

         // ---- pair query ----
         S_Q_DEP: begin
            dep_port.rd_addr0 = slot_of(req_ff.node_a);
            dep_port.rd_addr1 = slot_of(req_ff.node_b);
            state_in          = S_Q_SWAP;
         end

         S_Q_SWAP: begin
            if (dep_q0 < dep_q1) begin
               a_next = req_ff.node_b;
               b_in   = req_ff.node_a;
               db_in  = dep_q0;
            end else begin
               a_next = req_ff.node_a;
               b_in   = req_ff.node_b;
               db_in  = dep_q1;
            end
            a_in              = a_next;
            dsum_in           = DIST_W'(dep_q0) + DIST_W'(dep_q1);
            anc_port.rd_addr0 = anc_addr(a_next, TOP_IDX);
            lvl_in            = LVL_TOP;
            state_in          = S_Q_UP;
         end

         // lifting pass: ancestor read, then its depth, in S_Q_UP and S_Q_CMP per level
         S_Q_UP: begin
            up_in             = anc_q0;
            dep_port.rd_addr0 = slot_of(anc_q0);
            state_in          = S_Q_CMP;
         end

         S_Q_CMP: begin
            a_next = (dep_q0 >= db_ff) ? up_ff : a_ff;
            a_in   = a_next;
            if (lvl_ff == '0) begin
               if (a_next == b_ff) begin
                  up_in             = a_next;
                  dep_port.rd_addr0 = slot_of(a_next);
                  state_in          = S_Q_DIST;
               end else begin
                  anc_port.rd_addr0 = anc_addr(a_next, TOP_IDX);
                  anc_port.rd_addr1 = anc_addr(b_ff, TOP_IDX);
                  lvl_in            = LVL_TOP;
                  state_in          = S_Q_P2;
               end
            end else begin
               anc_port.rd_addr0 = anc_addr(a_next, lvl_dn_idx);
               lvl_in            = lvl_ff - 1'b1;
               state_in          = S_Q_UP;
            end
         end

         // joint pass: both ancestors on the two read ports, one level a cycle
         S_Q_P2: begin
            if (anc_q0 != anc_q1) begin
               a_next = anc_q0;
               b_next = anc_q1;
            end
            a_in = a_next;
            b_in = b_next;
            if (lvl_ff == '0) begin
               anc_port.rd_addr0 = anc_addr(a_next, '0);
               state_in          = S_Q_FIN;
            end else begin
               anc_port.rd_addr0 = anc_addr(a_next, lvl_dn_idx);
               anc_port.rd_addr1 = anc_addr(b_next, lvl_dn_idx);
               lvl_in            = lvl_ff - 1'b1;
            end
         end

         S_Q_FIN: begin
            up_in             = anc_q0;
            dep_port.rd_addr0 = slot_of(anc_q0);
            state_in          = S_Q_DIST;
         end

         S_Q_DIST: begin
            two_d              = DIST_W'({dep_q0, 1'b0});
            rsp_in.result_node = up_ff;
            rsp_in.distance    = (dsum_ff >= two_d) ? (dsum_ff - two_d) : '0;
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      up_ff   <= up_in;
      db_ff   <= db_in;
      dsum_ff <= dsum_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> rtl/core/tree_ancestor_query_engine.sv
// ---------------------------------------------------------------------------
// Tree ancestor query engine
// Binary-lifting ancestor table with loads, common-ancestor and distance
// queries, and kth-ancestor queries.
// ---------------------------------------------------------------------------
// Usage:
//   A request word is taken at a rising edge with start high and busy low.
//   kind load fills the node's depth and ancestor row (parents loaded first),
//   kind pair returns the common ancestor and path length, kind kth returns
//   the ancestor that many levels up, saturating at the root.
//   Each request gives one result word on rsp_word, marked by rsp_valid for
//   exactly one cycle; the receiver cannot stall, so it must take it then.
//   Every read of the ancestor and depth memories is registered; a load or
//   kth request walks the ancestor memory one level per read. A pair query
//   first lifts the deeper node, waiting on a depth memory read after each
//   ancestor read; unless one node lies above the other, a joint pass over
//   both nodes follows. busy drops as rsp_valid rises, so a new request can
//   be taken at the next edge.
//   Reset clears the sequencer only; memory contents stay undefined until
//   loaded, and no clearing pass runs.
// ---------------------------------------------------------------------------
module tree_ancestor_query_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tqe_pkg::req_type req_word,
   output logic             rsp_valid,
   output tqe_pkg::rsp_type rsp_word
);

   import tqe_pkg::*;

   anc_port_type anc_port;
   dep_port_type dep_port;
   node_type     anc_q0;
   node_type     anc_q1;
   depth_type    dep_q0;
   depth_type    dep_q1;

   tqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .anc_port  (anc_port),
      .anc_q0    (anc_q0),
      .anc_q1    (anc_q1),
      .dep_port  (dep_port),
      .dep_q0    (dep_q0),
      .dep_q1    (dep_q1)
   );

   tqe_ram #(
      .DEPTH (ANC_DEPTH),
      .WIDTH (NODE_W)
   ) u_anc_ram (
      .clock    (clock),
      .wr_en    (anc_port.wr_en),
      .wr_addr  (anc_port.wr_addr),
      .wr_data  (anc_port.wr_data),
      .rd_addr0 (anc_port.rd_addr0),
      .rd_addr1 (anc_port.rd_addr1),
      .rd_data0 (anc_q0),
      .rd_data1 (anc_q1)
   );

   tqe_ram #(
      .DEPTH (MAX_NODES),
      .WIDTH (DEPTH_W)
   ) u_dep_ram (
      .clock    (clock),
      .wr_en    (dep_port.wr_en),
      .wr_addr  (dep_port.wr_addr),
      .wr_data  (dep_port.wr_data),
      .rd_addr0 (dep_port.rd_addr0),
      .rd_addr1 (dep_port.rd_addr1),
      .rd_data0 (dep_q0),
      .rd_data1 (dep_q1)
   );

endmodule

>>> rtl/core/tqe_checker.sv
// ---------------------------------------------------------------------------
// Tree ancestor query engine checker
// Port-level properties of the request/result sequencing, bound to the top.
// ---------------------------------------------------------------------------
`include "tree_ancestor_query_engine_defines.svh"

module tqe_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every accepted word makes the engine busy in the following cycle
   `TQE_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy, "accept without busy")

   // the engine only goes idle by delivering a result word
   `TQE_ASSERT_NOW(a_done_gives_result, clock, reset, !$past(reset) && $fell(busy), rsp_valid, "idle without result")

   `TQE_ASSERT_NOW(a_result_when_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")

   `TQE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")

endmodule

bind tree_ancestor_query_engine tqe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the tree ancestor query engine
// Loads small forests, one very deep ping-pong chain and random trees, then
// checks every result word against a pinned value or a binary-lifting predictor held here.
// ----------------------------------------------------------------------------
module tb_top;
   import tqe_pkg::*;

   localparam kind_type KIND_SPARE = kind_type'(3);

   typedef struct packed {
      logic    fixed;
      rsp_type want;
   } pin_type;

   typedef struct packed {
      req_type req;
      pin_type pin;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   // predictor state; node numbers span the tables exactly
   node_type  lift_row [MAX_NODES][LEVELS];
   depth_type depth_of [MAX_NODES];

   // stimulus side view of which nodes have been loaded
   bit        known [MAX_NODES];
   node_type  known_list [$];
   node_type  last_load;

   rsp_type   pending_rsp [$];
   pin_type   pin_q [$];
   row_type   directed_rows [$];
   int        faults = 0;

   tree_ancestor_query_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic node_type common_root(input node_type a_in, input node_type b_in);
      node_type a;
      node_type b;
      node_type t;
      node_type ua;
      node_type ub;
      a = a_in;
      b = b_in;
      if (depth_of[a] < depth_of[b]) begin
         t = a;
         a = b;
         b = t;
      end
      for (int i = LEVELS - 1; i >= 0; i--) begin
         ua = lift_row[a][i];
         if (depth_of[ua] >= depth_of[b]) a = ua;
      end
      if (a == b) return a;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         ua = lift_row[a][i];
         ub = lift_row[b][i];
         if (ua != ub) begin
            a = ua;
            b = ub;
         end
      end
      return lift_row[a][0];
   endfunction

   function automatic rsp_type tree_answer(input req_type q);
      rsp_type   r;
      depth_type d;
      node_type  u;
      int        p;
      int        k;
      r = '0;
      case (q.kind)
         KIND_LOAD: begin
            d = '0;
            if (q.parent_node != q.node_a) begin
               d = (depth_of[q.parent_node] == DEPTH_MAX) ? DEPTH_MAX
                                                           : depth_of[q.parent_node] + 1'b1;
            end
            depth_of[q.node_a]    = d;
            lift_row[q.node_a][0] = q.parent_node;
            // row is rebuilt in place, lower levels first
            for (int i = 1; i < LEVELS; i++) begin
               lift_row[q.node_a][i] = lift_row[lift_row[q.node_a][i-1]][i-1];
            end
            r.result_node = q.node_a;
            r.distance    = dist_type'(d);
         end
         KIND_PAIR: begin
            u = common_root(q.node_a, q.node_b);
            p = int'(depth_of[q.node_a]) + int'(depth_of[q.node_b]) - 2 * int'(depth_of[u]);
            r.result_node = u;
            r.distance    = (p < 0) ? '0 : dist_type'(p);
         end
         KIND_KTH: begin
            k = (q.steps > depth_of[q.node_a]) ? int'(depth_of[q.node_a]) : int'(q.steps);
            u = q.node_a;
            for (int i = 0; i < LEVELS; i++) begin
               if (k[i]) u = lift_row[u][i];
            end
            r.result_node = u;
         end
         default: ;
      endcase
      return r;
   endfunction

   // result check first, then prediction of the word taken at this edge
   always @(posedge clock) begin : watch
      rsp_type want;
      pin_type pin;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_rsp.size() == 0) begin
               faults++;
               if (faults <= 10) begin
                  $display("unexpected result word: node %0d dist %0d",
                           rsp_word.result_node, rsp_word.distance);
               end
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_word.result_node !== want.result_node ||
                   rsp_word.distance !== want.distance) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("mismatch: expected node %0d dist %0d, got node %0d dist %0d",
                              want.result_node, want.distance,
                              rsp_word.result_node, rsp_word.distance);
                  end
               end
            end
         end
         if (start && busy === 1'b0) begin
            pin  = pin_q.pop_front();
            want = tree_answer(req_word);
            if (pin.fixed) want = pin.want;
            pending_rsp = {pending_rsp, want};
         end
      end
   end

   task automatic put_row(input kind_type k, input int a, b, p, s,
                          input bit fixed, input int res, dst);
      row_type w;
      w.req.kind             = k;
      w.req.node_a           = node_type'(a);
      w.req.node_b           = node_type'(b);
      w.req.parent_node      = node_type'(p);
      w.req.steps            = node_type'(s);
      w.pin.fixed            = fixed;
      w.pin.want.result_node = node_type'(res);
      w.pin.want.distance    = dist_type'(dst);
      directed_rows = {directed_rows, w};
   endtask

   function automatic void note_load(input node_type n);
      if (!known[n]) known_list = {known_list, n};
      known[n]  = 1'b1;
      last_load = n;
   endfunction

   function automatic node_type any_known();
      return known_list[$urandom_range(0, known_list.size() - 1)];
   endfunction

   function automatic req_type blank_word();
      req_type q;
      q.kind        = kind_type'($urandom_range(0, 3));
      q.node_a      = node_type'($urandom_range(0, 1023));
      q.node_b      = node_type'($urandom_range(0, 1023));
      q.parent_node = node_type'($urandom_range(0, 1023));
      q.steps       = node_type'($urandom_range(0, 1023));
      return q;
   endfunction

   // mostly growth of well-formed trees and queries on loaded nodes;
   // reloads and the spare kind as noise
   function automatic req_type pick_word();
      req_type  q;
      int       r;
      node_type n;
      q = blank_word();
      r = $urandom_range(0, 99);
      if (r < 30 && known_list.size() < MAX_NODES) begin
         q.kind = KIND_LOAD;
         do n = node_type'($urandom_range(0, MAX_NODES - 1)); while (known[n]);
         q.node_a = n;
         r = $urandom_range(0, 19);
         q.parent_node = (r == 0) ? n : (r < 11) ? last_load : any_known();
      end else if (r < 35) begin
         q.kind        = KIND_LOAD;
         q.node_a      = any_known();
         q.parent_node = ($urandom_range(0, 7) == 0) ? q.node_a : any_known();
      end else if (r < 63) begin
         q.kind   = KIND_PAIR;
         q.node_a = any_known();
         q.node_b = ($urandom_range(0, 9) == 0) ? q.node_a : any_known();
      end else if (r < 92) begin
         q.kind   = KIND_KTH;
         q.node_a = any_known();
         q.steps  = $urandom_range(0, 1) ? node_type'($urandom_range(0, 24))
                                         : node_type'($urandom_range(0, 1023));
      end else begin
         q.kind = KIND_SPARE;
      end
      if (q.kind == KIND_LOAD) note_load(q.node_a);
      return q;
   endfunction

   // leaves start high when the next word follows at once
   task automatic send_word(input req_type q, input bit fixed, input rsp_type want);
      pin_type pin;
      pin.fixed = fixed;
      pin.want  = want;
      start    <= 1'b1;
      req_word <= q;
      pin_q = {pin_q, pin};
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic idle_gap(input bit allow);
      if (allow && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   initial begin : drive
      req_type q;
      node_type n;
      int spin;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;

      // spare kind, then two roots and a small tree
      put_row(KIND_SPARE, 0, 0, 0, 0, 1, 0, 0);
      put_row(KIND_SPARE, 1023, 1023, 1023, 1023, 1, 0, 0);
      put_row(KIND_LOAD, 0, 0, 0, 0, 1, 0, 0);
      put_row(KIND_LOAD, 1023, 0, 1023, 0, 1, 1023, 0);
      put_row(KIND_LOAD, 1, 0, 0, 0, 1, 1, 1);
      put_row(KIND_LOAD, 2, 0, 1, 0, 1, 2, 2);
      put_row(KIND_LOAD, 3, 0, 1, 0, 1, 3, 2);
      put_row(KIND_LOAD, 1022, 0, 1023, 0, 1, 1022, 1);
      put_row(KIND_PAIR, 2, 3, 0, 0, 1, 1, 2);
      put_row(KIND_PAIR, 2, 2, 0, 0, 1, 2, 0);
      put_row(KIND_PAIR, 0, 2, 0, 0, 1, 0, 2);
      put_row(KIND_PAIR, 2, 1022, 0, 0, 0, 0, 0);
      put_row(KIND_PAIR, 1022, 1023, 0, 0, 1, 1023, 1);
      put_row(KIND_KTH, 2, 0, 0, 0, 1, 2, 0);
      put_row(KIND_KTH, 2, 0, 0, 1, 1, 1, 0);
      put_row(KIND_KTH, 2, 0, 0, 1023, 1, 0, 0);
      put_row(KIND_KTH, 1022, 0, 0, 1023, 1, 1023, 0);
      // a node reloaded below its own grandchild: common ancestor deeper
      // than the path allows, so the distance clamps
      put_row(KIND_LOAD, 5, 0, 0, 0, 1, 5, 1);
      put_row(KIND_LOAD, 6, 0, 5, 0, 1, 6, 2);
      put_row(KIND_LOAD, 7, 0, 6, 0, 1, 7, 3);
      put_row(KIND_LOAD, 5, 0, 7, 0, 1, 5, 4);
      put_row(KIND_PAIR, 6, 6, 0, 0, 0, 0, 0);
      put_row(KIND_KTH, 6, 0, 0, 1023, 0, 0, 0);
      put_row(KIND_PAIR, 3, 7, 0, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].req.kind == KIND_LOAD) note_load(directed_rows[i].req.node_a);
         send_word(directed_rows[i].req, directed_rows[i].pin.fixed,
                   directed_rows[i].pin.want);
         idle_gap(1'b1);
      end

      // two nodes loaded under each other in turn: depth climbs one per word
      // until it saturates
      q = blank_word();
      q.kind        = KIND_LOAD;
      q.node_a      = node_type'(10);
      q.parent_node = node_type'(0);
      note_load(q.node_a);
      send_word(q, 1'b0, '0);
      for (int i = 0; i < 1024; i++) begin
         n = last_load;
         q = blank_word();
         q.kind        = KIND_LOAD;
         q.node_a      = (n == node_type'(10)) ? node_type'(11) : node_type'(10);
         q.parent_node = n;
         note_load(q.node_a);
         send_word(q, 1'b0, '0);
         idle_gap(1'b1);
      end
      q = blank_word();
      q.kind        = KIND_LOAD;
      q.node_a      = node_type'(12);
      q.parent_node = last_load;
      note_load(q.node_a);
      send_word(q, 1'b0, '0);
      for (int i = 0; i < 12; i++) begin
         q = blank_word();
         q.kind   = (i % 2 == 0) ? KIND_PAIR : KIND_KTH;
         q.node_a = node_type'(10 + i % 3);
         q.node_b = (i < 6) ? node_type'(1022) : node_type'(12 - i % 3);
         send_word(q, 1'b0, '0);
         idle_gap(1'b1);
      end

      for (int i = 0; i < 60; i++) begin
         send_word(pick_word(), 1'b0, '0);
         idle_gap(i < 40);
      end

      start <= 1'b0;
      @(posedge clock);
      spin = 0;
      while (pending_rsp.size() != 0 && spin < 500) begin
         @(posedge clock);
         spin++;
      end
      repeat (40) @(posedge clock);
      if (faults == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tqe_pkg.sv
rtl/core/tqe_ram.sv
rtl/core/tqe_ctrl.sv
rtl/core/tree_ancestor_query_engine.sv
rtl/core/tqe_checker.sv
tb/tb_top.sv
